// ===== hdl/stqf_pkg.sv =====
// shared constants, types and helpers for the sine unit
// fixed-point angle constants, reciprocal factorial table, pipeline sideband types
// no dependencies
package stqf_pkg;

   // angle constants in unsigned Q56
   localparam logic [63:0] PI_Q56            = 64'h0324_3F6A_8885_A309;
   localparam logic [63:0] HALF_PI_Q56       = 64'h0192_1FB5_4442_D185;
   localparam logic [63:0] TWO_PI_Q56        = 64'h0648_7ED5_110B_4612;
   localparam logic [63:0] THREE_HALF_PI_Q56 = PI_Q56 + HALF_PI_Q56;

   localparam int NUM_TERMS     = 10;
   localparam int REDUCE_STAGES = 5;

   // signal widths
   localparam int CNT_W   = 4;   // term count 0..10
   localparam int LIM_W   = 5;   // series limit register
   localparam int RED_W   = 64;  // magnitude in Q56 before reduction
   localparam int FOLD_W  = 57;  // folded angle in Q56, at most pi/2
   localparam int Y_W     = 49;  // folded angle in Q48
   localparam int Y2_W    = 50;  // square of the angle in Q48
   localparam int P_W     = 61;  // odd power of the angle in Q48
   localparam int RCP_W   = 63;  // reciprocal factorial in Q62
   localparam int TERM_W  = 50;  // series term magnitude in Q48
   localparam int SUM_W   = 52;  // signed partial sum in Q48
   localparam int MUL_W   = 64;  // multiplier operand width
   localparam int OUT_W   = 32;

   localparam logic [CNT_W-1:0] TERM_COUNT_RESET = CNT_W'(5);
   localparam logic [CNT_W-1:0] TERM_COUNT_MAX   = CNT_W'(NUM_TERMS);
   localparam logic [30:0]      ONE_Q30          = 31'h4000_0000;

   localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

   // 1/n! for n = 1, 3, ..., 19 in Q62, rounded to nearest
   localparam logic [RCP_W-1:0] RECIP_FACT [NUM_TERMS] = '{
      RCP_W'((ONE_Q62 + 64'd1 / 64'd2) / 64'd1),
      RCP_W'((ONE_Q62 + 64'd6 / 64'd2) / 64'd6),
      RCP_W'((ONE_Q62 + 64'd120 / 64'd2) / 64'd120),
      RCP_W'((ONE_Q62 + 64'd5040 / 64'd2) / 64'd5040),
      RCP_W'((ONE_Q62 + 64'd362880 / 64'd2) / 64'd362880),
      RCP_W'((ONE_Q62 + 64'd39916800 / 64'd2) / 64'd39916800),
      RCP_W'((ONE_Q62 + 64'd6227020800 / 64'd2) / 64'd6227020800),
      RCP_W'((ONE_Q62 + 64'd1307674368000 / 64'd2) / 64'd1307674368000),
      RCP_W'((ONE_Q62 + 64'd355687428096000 / 64'd2) / 64'd355687428096000),
      RCP_W'((ONE_Q62 + 64'd121645100408832000 / 64'd2) / 64'd121645100408832000)
   };

   // moduli for the restoring reduction, largest first
   localparam logic [RED_W-1:0] REDUCE_MOD [REDUCE_STAGES] = '{
      TWO_PI_Q56 << 4, TWO_PI_Q56 << 3, TWO_PI_Q56 << 2, TWO_PI_Q56 << 1, TWO_PI_Q56
   };

   typedef enum logic {
      SHIFT_Q48,
      SHIFT_Q62
   } shift_type;

   // travels with every beat down the pipeline
   typedef struct packed {
      logic vld;
      logic neg;
   } side_type;

   // one series term handed to the next accumulator
   typedef struct packed {
      logic              en;
      logic              sub;
      logic [TERM_W-1:0] mag;
   } term_type;

   function automatic logic signed [SUM_W-1:0] acc_step(
      input logic signed [SUM_W-1:0] sum,
      input term_type                t
   );
      logic signed [SUM_W-1:0] ext;
      logic signed [SUM_W-1:0] res;
      ext = signed'({2'b00, t.mag});
      priority if (!t.en) begin
         res = sum;
      end else if (t.sub) begin
         res = sum - ext;
      end else begin
         res = sum + ext;
      end
      return res;
   endfunction

endpackage

// ===== hdl/stqf_mul_shift.sv =====
// two-stage 64x64 unsigned multiply with round-half-up and right shift by 48 or 62
// built from four registered 32x32 partial products
// depends on stqf_pkg
module stqf_mul_shift (
   input  logic                       clock,
   input  logic                       adv,
   input  stqf_pkg::shift_type        shift_sel,
   input  logic [stqf_pkg::MUL_W-1:0] a,
   input  logic [stqf_pkg::MUL_W-1:0] b,
   output logic [stqf_pkg::MUL_W-1:0] prod
);
   import stqf_pkg::*;

   localparam int HALF_W = MUL_W / 2;
   localparam int FULL_W = 2 * MUL_W;

   logic [MUL_W-1:0]  ll_ff, lh_ff, hl_ff, hh_ff;
   logic [MUL_W-1:0]  ll_in, lh_in, hl_in, hh_in;
   logic [FULL_W-1:0] rnd;
   logic [FULL_W-1:0] full;
   logic [MUL_W-1:0]  prod_ff, prod_in;

   always_comb begin
      ll_in = MUL_W'(a[HALF_W-1:0])     * MUL_W'(b[HALF_W-1:0]);
      lh_in = MUL_W'(a[HALF_W-1:0])     * MUL_W'(b[MUL_W-1:HALF_W]);
      hl_in = MUL_W'(a[MUL_W-1:HALF_W]) * MUL_W'(b[HALF_W-1:0]);
      hh_in = MUL_W'(a[MUL_W-1:HALF_W]) * MUL_W'(b[MUL_W-1:HALF_W]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
      end
   end

   always_comb begin
      unique case (shift_sel)
         SHIFT_Q48: rnd = FULL_W'(1) << 47;
         SHIFT_Q62: rnd = FULL_W'(1) << 61;
         default:   rnd = '0;
      endcase
      full = FULL_W'(ll_ff)
           + (FULL_W'(lh_ff) << HALF_W)
           + (FULL_W'(hl_ff) << HALF_W)
           + (FULL_W'(hh_ff) << MUL_W)
           + rnd;
      unique case (shift_sel)
         SHIFT_Q48: prod_in = full[48 +: MUL_W];
         SHIFT_Q62: prod_in = full[62 +: MUL_W];
         default:   prod_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

// ===== hdl/stqf_reduce_cell.sv =====
// one compare-and-subtract step of the modulo 2*pi reduction
// depends on stqf_pkg
module stqf_reduce_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic [stqf_pkg::RED_W-1:0] modulus,
   input  stqf_pkg::side_type         side_in,
   input  logic [stqf_pkg::RED_W-1:0] r_in,
   output stqf_pkg::side_type         side_out,
   output logic [stqf_pkg::RED_W-1:0] r_out
);
   import stqf_pkg::*;

   side_type         side_ff;
   logic [RED_W-1:0] r_ff, r_in_next;
   logic [RED_W:0]   diff;

   always_comb begin
      diff      = {1'b0, r_in} - {1'b0, modulus};
      // borrow clear means r_in >= modulus
      r_in_next = diff[RED_W] ? r_in : diff[RED_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else if (adv) begin
         side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_ff <= r_in_next;
      end
   end

   assign side_out = side_ff;
   assign r_out    = r_ff;

endmodule

// ===== hdl/stqf_term_cell.sv =====
// one series cell: accumulates the previous term, forms p*(1/n!) and the next odd power
// two stages deep, matching the split multipliers
// depends on stqf_pkg, stqf_mul_shift
module stqf_term_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic [stqf_pkg::CNT_W-1:0]  idx,
   input  logic [stqf_pkg::CNT_W-1:0]  term_count,
   input  logic [stqf_pkg::RCP_W-1:0]  recip,
   input  stqf_pkg::side_type          side_in,
   input  logic [stqf_pkg::P_W-1:0]    p_in,
   input  logic [stqf_pkg::Y2_W-1:0]   y2_in,
   input  logic signed [stqf_pkg::SUM_W-1:0] sum_in,
   input  stqf_pkg::term_type          term_in,
   output stqf_pkg::side_type          side_out,
   output logic [stqf_pkg::P_W-1:0]    p_out,
   output logic [stqf_pkg::Y2_W-1:0]   y2_out,
   output logic signed [stqf_pkg::SUM_W-1:0] sum_out,
   output stqf_pkg::term_type          term_out
);
   import stqf_pkg::*;

   side_type                side1_ff, side2_ff;
   logic [Y2_W-1:0]         y2_1_ff, y2_2_ff;
   logic signed [SUM_W-1:0] sum1_ff, sum2_ff, sum1_in;
   logic [MUL_W-1:0]        term_prod, pow_prod;

   stqf_mul_shift u_term_mul (
      .clock     (clock),
      .adv       (adv),
      .shift_sel (SHIFT_Q62),
      .a         (MUL_W'(p_in)),
      .b         (MUL_W'(recip)),
      .prod      (term_prod)
   );

   stqf_mul_shift u_pow_mul (
      .clock     (clock),
      .adv       (adv),
      .shift_sel (SHIFT_Q48),
      .a         (MUL_W'(p_in)),
      .b         (MUL_W'(y2_in)),
      .prod      (pow_prod)
   );

   assign sum1_in = acc_step(sum_in, term_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         side1_ff <= '0;
         side2_ff <= '0;
      end else if (adv) begin
         side1_ff <= side_in;
         side2_ff <= side1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y2_1_ff <= y2_in;
         y2_2_ff <= y2_1_ff;
         sum1_ff <= sum1_in;
         sum2_ff <= sum1_ff;
      end
   end

   assign side_out     = side2_ff;
   assign p_out        = pow_prod[P_W-1:0];
   assign y2_out       = y2_2_ff;
   assign sum_out      = sum2_ff;
   // odd cells subtract; cells past the term count contribute nothing
   assign term_out.en  = (idx < term_count);
   assign term_out.sub = idx[0];
   assign term_out.mag = term_prod[TERM_W-1:0];

endmodule

// ===== hdl/sine_taylor_quadrant_fold_top.sv =====
// Sine unit: takes a signed Q7.24 angle in radians and returns its sine in signed
// Q1.30, saturated to +/-1.0. One angle is accepted every clock cycle unless the
// pipeline holds. Each angle passes through the sign split, the five-step modulo
// 2*pi reduction, the quadrant fold and rounding, the squaring multiplier and the
// row of ten series cells with their split 64-bit multipliers, followed by the final
// accumulate, magnitude and rounding stages. When the result port stalls with a
// beat waiting, the whole pipeline holds and req_stall rises. The term_limit
// register (reset 10) sets how many series terms are summed; write it only
// while no beat is in flight.
// depends on stqf_pkg, stqf_reduce_cell, stqf_term_cell, stqf_mul_shift
module sine_taylor_quadrant_fold_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_angle,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [31:0]  rsp_sine,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [4:0]          csr_term_limit
);
   import stqf_pkg::*;

   logic adv;

   // term count register
   logic [CNT_W-1:0] term_count_ff, term_count_in;
   logic [LIM_W:0]   limit_p1;
   logic [LIM_W-1:0] half_limit;

   always_comb begin
      limit_p1   = {1'b0, csr_term_limit} + (LIM_W+1)'(1);
      half_limit = limit_p1[LIM_W:1];
      term_count_in = (half_limit > LIM_W'(TERM_COUNT_MAX)) ? TERM_COUNT_MAX
                                                              : half_limit[CNT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         term_count_ff <= TERM_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         term_count_ff <= term_count_in;
      end
   end

   assign csr_ready = 1'b1;

   // pipeline advances unless a finished beat is held at the output
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // sign split and scale to Q56
   side_type         s0_side_ff;
   logic [RED_W-1:0] s0_x_ff;
   logic [31:0]      angle_u, angle_mag;

   always_comb begin
      angle_u   = req_angle;
      angle_mag = angle_u[31] ? (~angle_u + 32'd1) : angle_u;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_side_ff <= '0;
      end else if (adv) begin
         s0_side_ff <= '{vld: req_valid, neg: angle_u[31]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_x_ff <= {angle_mag, 32'd0};
      end
   end

   // modulo 2*pi reduction chain
   side_type         red_side [REDUCE_STAGES+1];
   logic [RED_W-1:0] red_r    [REDUCE_STAGES+1];

   assign red_side[0] = s0_side_ff;
   assign red_r[0]    = s0_x_ff;

   for (genvar j = 0; j < REDUCE_STAGES; j++) begin : g_reduce
      stqf_reduce_cell u_reduce (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .modulus  (REDUCE_MOD[j]),
         .side_in  (red_side[j]),
         .r_in     (red_r[j]),
         .side_out (red_side[j+1]),
         .r_out    (red_r[j+1])
      );
   end

   // quadrant fold into [0, pi/2]
   side_type          fold_side_ff, fold_side_in;
   logic [FOLD_W-1:0] fold_f_ff, fold_f_in;
   logic [RED_W-1:0]  r_red, fold_diff;

   always_comb begin
      r_red        = red_r[REDUCE_STAGES];
      fold_side_in = red_side[REDUCE_STAGES];
      priority if (r_red <= HALF_PI_Q56) begin
         fold_diff = r_red;
      end else if (r_red <= PI_Q56) begin
         fold_diff = PI_Q56 - r_red;
      end else if (r_red <= THREE_HALF_PI_Q56) begin
         fold_diff        = r_red - PI_Q56;
         fold_side_in.neg = !red_side[REDUCE_STAGES].neg;
      end else begin
         fold_diff        = TWO_PI_Q56 - r_red;
         fold_side_in.neg = !red_side[REDUCE_STAGES].neg;
      end
      fold_f_in = fold_diff[FOLD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_side_ff <= '0;
      end else if (adv) begin
         fold_side_ff <= fold_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fold_f_ff <= fold_f_in;
      end
   end

   // round to Q48
   side_type        y_side_ff;
   logic [Y_W-1:0]  y_ff;
   logic [FOLD_W:0] y_sum;

   assign y_sum = {1'b0, fold_f_ff} + (FOLD_W+1)'(128);

   always_ff @(posedge clock) begin
      if (reset) begin
         y_side_ff <= '0;
      end else if (adv) begin
         y_side_ff <= fold_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_ff <= y_sum[8 +: Y_W];
      end
   end

   // square of the angle
   side_type         sq_side1_ff, sq_side2_ff;
   logic [Y_W-1:0]   y_d1_ff, y_d2_ff;
   logic [MUL_W-1:0] sq_prod;

   stqf_mul_shift u_square (
      .clock     (clock),
      .adv       (adv),
      .shift_sel (SHIFT_Q48),
      .a         (MUL_W'(y_ff)),
      .b         (MUL_W'(y_ff)),
      .prod      (sq_prod)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_side1_ff <= '0;
         sq_side2_ff <= '0;
      end else if (adv) begin
         sq_side1_ff <= y_side_ff;
         sq_side2_ff <= sq_side1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         y_d1_ff <= y_ff;
         y_d2_ff <= y_d1_ff;
      end
   end

   // row of series cells
   side_type                cell_side [NUM_TERMS+1];
   logic [P_W-1:0]          cell_p    [NUM_TERMS+1];
   logic [Y2_W-1:0]         cell_y2   [NUM_TERMS+1];
   logic signed [SUM_W-1:0] cell_sum  [NUM_TERMS+1];
   term_type                cell_term [NUM_TERMS+1];

   assign cell_side[0] = sq_side2_ff;
   assign cell_p[0]    = P_W'(y_d2_ff);
   assign cell_y2[0]   = sq_prod[Y2_W-1:0];
   assign cell_sum[0]  = '0;
   assign cell_term[0] = '0;

   for (genvar k = 0; k < NUM_TERMS; k++) begin : g_term
      stqf_term_cell u_term (
         .clock      (clock),
         .reset      (reset),
         .adv        (adv),
         .idx        (CNT_W'(k)),
         .term_count (term_count_ff),
         .recip      (RECIP_FACT[k]),
         .side_in    (cell_side[k]),
         .p_in       (cell_p[k]),
         .y2_in      (cell_y2[k]),
         .sum_in     (cell_sum[k]),
         .term_in    (cell_term[k]),
         .side_out   (cell_side[k+1]),
         .p_out      (cell_p[k+1]),
         .y2_out     (cell_y2[k+1]),
         .sum_out    (cell_sum[k+1]),
         .term_out   (cell_term[k+1])
      );
   end

   // last accumulation
   side_type                acc_side_ff;
   logic signed [SUM_W-1:0] acc_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_side_ff <= '0;
      end else if (adv) begin
         acc_side_ff <= cell_side[NUM_TERMS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         acc_sum_ff <= acc_step(cell_sum[NUM_TERMS], cell_term[NUM_TERMS]);
      end
   end

   // magnitude of the sum, sign folded into the quadrant sign
   side_type         mag_side_ff, mag_side_in;
   logic [SUM_W-2:0] mag_ff, mag_in;
   logic [SUM_W-1:0] acc_neg;

   always_comb begin
      acc_neg         = -acc_sum_ff;
      mag_side_in     = acc_side_ff;
      mag_side_in.neg = acc_side_ff.neg ^ acc_sum_ff[SUM_W-1];
      mag_in          = acc_sum_ff[SUM_W-1] ? acc_neg[SUM_W-2:0] : acc_sum_ff[SUM_W-2:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_side_ff <= '0;
      end else if (adv) begin
         mag_side_ff <= mag_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff <= mag_in;
      end
   end

   // round to Q30, saturate, apply sign
   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_sine_ff, rsp_sine_in;
   logic [SUM_W-1:0]  q_sum;
   logic [SUM_W-19:0] q_full;
   logic [30:0]       q_sat;

   always_comb begin
      q_sum       = {1'b0, mag_ff} + SUM_W'(1 << 17);
      q_full      = q_sum[SUM_W-1:18];
      q_sat       = (q_full > (SUM_W-18)'(ONE_Q30)) ? ONE_Q30 : q_full[30:0];
      rsp_sine_in = mag_side_ff.neg ? -{1'b0, q_sat} : {1'b0, q_sat};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mag_side_ff.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_sine_ff <= rsp_sine_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sine  = rsp_sine_ff;

endmodule

// ===== hdl/stqf_checker.sv =====
// port-level checks for the sine unit, bound to the top level
// depends on sine_taylor_quadrant_fold_top
module stqf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic signed [31:0] req_angle,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_sine,
   input logic               csr_valid,
   input logic               csr_ready,
   input logic [4:0]         csr_term_limit
);

   // a held result beat keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_sine)))
      else $error("result beat changed while stalled");

   // saturation keeps the sine within one
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sine <= 32'sd1073741824 && rsp_sine >= -32'sd1073741824))
      else $error("sine outside plus or minus one");

   // input back-pressure comes only from a held result
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("req_stall does not follow output back-pressure");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat present after reset");

endmodule

bind sine_taylor_quadrant_fold_top stqf_checker u_stqf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .req_angle      (req_angle),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_sine       (rsp_sine),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready),
   .csr_term_limit (csr_term_limit)
);

// ===== sim/sine_taylor_quadrant_fold_top_tb.sv =====
// self-checking bench for the pipelined sine unit: Q7.24 angles in, Q1.30 sines out
// bit-exact fixed-point predictor, random idling on both channels, one long result hold-off
// depends on sine_taylor_quadrant_fold_top and its package
module sine_taylor_quadrant_fold_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // angle constants in unsigned Q56
   localparam logic [63:0] PI_Q56        = 64'h0324_3F6A_8885_A309;
   localparam logic [63:0] HALF_PI_Q56   = 64'h0192_1FB5_4442_D185;
   localparam logic [63:0] TWO_PI_Q56    = 64'h0648_7ED5_110B_4612;
   localparam logic [63:0] THREE_HALF_Q56 = PI_Q56 + HALF_PI_Q56;
   localparam logic [63:0] ONE_Q30       = 64'h4000_0000;
   localparam int          SERIES_MAX    = 10;
   localparam logic [4:0]  LIMIT_AT_RESET = 5'd10;
   localparam int          PIPE_DEPTH    = 33;
   localparam int          HOLD_CYCLES   = 250;
   localparam int          WATCHDOG_LIMIT = 3000;
   localparam int          ANGLES_PER_SETTING = 104;
   localparam int          MAX_REPORTS   = 40;

   logic               clock;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_angle = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_sine;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [4:0]         csr_term_limit = '0;

   sine_taylor_quadrant_fold_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_angle      (req_angle),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sine       (rsp_sine),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_term_limit (csr_term_limit)
   );

   logic [63:0]        inv_odd_fact [SERIES_MAX];
   logic [4:0]         term_limit_now = LIMIT_AT_RESET;
   logic [31:0]        angles_to_send [$];
   logic signed [31:0] sine_due [$];
   logic signed [31:0] sine_want;
   logic               req_took = 1'b0;
   logic               calm = 1'b0;
   int                 gap_left = 0;
   int                 stall_left = 0;
   int                 hold_left = 0;
   int                 hold_asks = 0;
   int                 hold_served = 0;
   int                 quiet_cycles = 0;
   int                 n_angles = 0;
   int                 n_sines = 0;
   int                 n_backpressure = 0;
   int                 n_settings = 0;
   int                 n_errors = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // (a*b) rounded half up, shifted right by s
   function automatic logic [63:0] mul_round(input logic [63:0] a, input logic [63:0] b,
                                             input int unsigned s);
      logic [127:0] prod;
      prod = {64'd0, a} * {64'd0, b};
      prod = prod + (128'd1 << (s - 1));
      prod = prod >> s;
      return prod[63:0];
   endfunction

   function automatic logic signed [31:0] predict_sine(input logic [31:0] ang,
                                                       input logic [4:0] lim);
      logic               neg;
      logic               sneg;
      logic [63:0]        mag;
      logic [63:0]        r;
      logic [63:0]        f;
      logic [63:0]        y;
      logic [63:0]        y2;
      logic [63:0]        p;
      logic [63:0]        t;
      logic [63:0]        smag;
      logic [63:0]        q;
      logic signed [63:0] acc;
      logic [31:0]        res;
      int                 n_terms;
      neg = ang[31];
      mag = {32'd0, neg ? -ang : ang};
      r = (mag << 32) % TWO_PI_Q56;
      if (r <= HALF_PI_Q56) begin
         f = r;
      end else if (r <= PI_Q56) begin
         f = PI_Q56 - r;
      end else if (r <= THREE_HALF_Q56) begin
         f = r - PI_Q56;
         neg = !neg;
      end else begin
         f = TWO_PI_Q56 - r;
         neg = !neg;
      end
      y = (f + 64'd128) >> 8;
      y2 = mul_round(y, y, 48);
      n_terms = (lim + 1) / 2;
      if (n_terms > SERIES_MAX) n_terms = SERIES_MAX;
      acc = '0;
      p = y;
      for (int k = 0; k < n_terms; k++) begin
         t = mul_round(p, inv_odd_fact[k], 62);
         acc = (k % 2 == 1) ? acc - $signed(t) : acc + $signed(t);
         if (k + 1 < n_terms) p = mul_round(p, y2, 48);
      end
      sneg = acc < 0;
      smag = sneg ? -acc : acc;
      q = (smag + 64'd131072) >> 18;
      if (q > ONE_Q30) q = ONE_Q30;
      if (sneg) neg = !neg;
      res = neg ? -q[31:0] : q[31:0];
      return $signed(res);
   endfunction

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // angle near k quarter turns, with k up to the top of the Q7.24 range
   function automatic logic [31:0] near_quadrant_edge();
      logic [63:0] edge_q56;
      logic [31:0] a;
      edge_q56 = 64'($urandom_range(1, 81)) * HALF_PI_Q56;
      a = edge_q56[63:32] + 32'($signed($urandom_range(0, 8)) - 4);
      return a;
   endfunction

   function automatic logic [31:0] random_angle();
      logic [31:0] a;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: a = $urandom;
         4, 5, 6:    a = $urandom_range(0, 32'h0800_0000);
         7, 8:       a = near_quadrant_edge();
         default:    a = 32'h7FFF_FFFF - $urandom_range(0, 15);
      endcase
      if ($urandom_range(0, 1) == 1) a = -a;
      return a;
   endfunction

   task automatic report_mismatch(input string what);
      if (n_errors < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, what);
      n_errors++;
   endtask

   task automatic write_term_limit(input logic [4:0] lim);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_term_limit <= lim;
      do @(posedge clock); while (!csr_ready);
      term_limit_now = lim;
      n_settings++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (angles_to_send.size() != 0 || req_valid || sine_due.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (angles_to_send.size() != 0) begin
            req_valid <= 1'b1;
            req_angle <= angles_to_send.pop_front();
            gap_left = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result-side stall, with the long hold-off counted here
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_asks != hold_served) begin
         hold_served++;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if ($urandom_range(0, 4) == 0) stall_left = pick_gap();
      end
   end

   // predict on every accepted angle, check every accepted sine
   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && !req_stall;
         if (req_valid && req_stall) n_backpressure++;
         if (req_valid && !req_stall) begin
            sine_due.push_back(predict_sine(req_angle, term_limit_now));
            n_angles++;
         end
         if (rsp_valid && !rsp_stall) begin
            n_sines++;
            if (sine_due.size() == 0) begin
               report_mismatch($sformatf("sine %h with no angle pending", rsp_sine));
            end else begin
               sine_want = sine_due.pop_front();
               if (rsp_sine !== sine_want)
                  report_mismatch($sformatf("sine got %h want %h", rsp_sine, sine_want));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("no handshake for %0d cycles", quiet_cycles);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [63:0] fact;
      logic [4:0]  limit_plan [12];
      logic [31:0] hp24;
      logic [31:0] pi24;
      logic [31:0] thp24;
      logic [31:0] tp24;
      limit_plan = '{5'd19, 5'd0, 5'd31, 5'd1, 5'd20, 5'd2, 5'd18, 5'd7, 5'd12,
                     5'd3, 5'd10, 5'd5};
      fact = 64'd1;
      for (int n = 1; n <= 19; n++) begin
         fact = fact * 64'(n);
         if (n % 2 == 1) inv_odd_fact[n / 2] = ((64'd1 << 62) + fact / 2) / fact;
      end
      hp24 = HALF_PI_Q56[63:32];
      pi24 = PI_Q56[63:32];
      thp24 = THREE_HALF_Q56[63:32];
      tp24 = TWO_PI_Q56[63:32];

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed angles at the reset series limit
      angles_to_send = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                         32'h8000_0001, 32'h0100_0000, 32'h0000_0100, hp24, hp24 + 1,
                         pi24, pi24 + 1, thp24, thp24 + 1, tp24, tp24 + 1, -hp24,
                         -(pi24 + 1), -thp24, 32'h4000_0000, 32'hC000_0000};
      wait_drained();

      // sweep series limits; one setting gets the long result hold-off
      for (int s = 0; s < 12; s++) begin
         write_term_limit(limit_plan[s]);
         calm = (s % 4 == 3);
         for (int i = 0; i < ANGLES_PER_SETTING; i++) angles_to_send.push_back(random_angle());
         if (s == 2) hold_asks++;
         wait_drained();
      end
      calm = 1'b0;

      // anything arriving late would still be flagged by the checker
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (sine_due.size() != 0) report_mismatch("sines still pending at end");

      $display("checked %0d sines from %0d angles across %0d series-limit settings",
               n_sines, n_angles, n_settings + 1);
      $display("input held off for %0d cycles, %0d mismatches", n_backpressure, n_errors);
      if (n_errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
